>>> design/psd_pkg.sv
// Shared widths, pipeline stage indexes and types of the point-to-segment distance unit.
// No dependencies; every other file of the block imports this package.
package psd_pkg;

  localparam int COORD_W  = 24;               // input coordinate width
  localparam int WIDTH_W  = COORD_W - 1;      // line width field
  localparam int DIST_W   = COORD_W + 1;      // distance result field
  localparam int MAG_W    = COORD_W + 1;      // bare segment direction components
  localparam int CW       = COORD_W + 2;      // coordinates of an extended segment
  localparam int DW       = CW + 1;           // differences inside the metric
  localparam int PW       = 2 * DW;           // products inside the metric
  localparam int NUM_W    = 2 * PW;           // squared distance numerator
  localparam int DEN_W    = PW;               // squared distance denominator
  localparam int EPROD_W  = MAG_W + WIDTH_W;  // |d| * w
  localparam int EHALF_W  = EPROD_W / 2;
  localparam int ENUM_W   = 2 * EPROD_W;      // (|d| * w)^2
  localparam int EL2_W    = 2 * MAG_W + 1;    // bare squared length
  localparam int EXT_BITS = WIDTH_W;          // extension never exceeds the width
  localparam int FIN_BITS = 32;               // bits of the final square root
  localparam int RW       = DEN_W + 2 * (FIN_BITS - 1) + 4;
  localparam int MET_LAT  = 5;                // register stages of psd_metric

  // Pipeline stage indexes, counted from the input register.
  localparam int ST_EXT_IN = 4;
  localparam int ST_BARE   = MET_LAT;
  localparam int ST_INS    = ST_BARE + 3;
  localparam int ST_G      = ST_EXT_IN + EXT_BITS + 1;
  localparam int ST_FIN_IN = ST_G + MET_LAT;
  localparam int ST_OUT    = ST_FIN_IN + FIN_BITS + 1;

  typedef struct packed {
    logic                      func;
    logic [WIDTH_W-1:0]        line_w;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } ctx_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } pts_t;

  // Running state of the bit-serial ratio square root.
  typedef struct packed {
    logic [RW-1:0]       num;
    logic [RW-1:0]       sq;
    logic [RW-1:0]       y;
    logic [RW-1:0]       d2;
    logic [FIN_BITS-1:0] r;
  } root_t;

endpackage

>>> design/psd_in_if.sv
// Input channel of the point-to-segment distance unit: valid, ready and one query item.
// Depends on psd_pkg.
interface psd_in_if import psd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [COORD_W-1:0] seg_start_x;
  logic signed [COORD_W-1:0] seg_start_y;
  logic signed [COORD_W-1:0] seg_end_x;
  logic signed [COORD_W-1:0] seg_end_y;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [WIDTH_W-1:0]        line_width;

  modport source (output valid, func, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  point_x, point_y, line_width, input ready);
  modport sink (input valid, func, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                point_x, point_y, line_width, output ready);
endinterface

>>> design/psd_out_if.sv
// Output channel of the point-to-segment distance unit: valid, ready and one result item.
// Depends on psd_pkg.
interface psd_out_if import psd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              inside_res;

  modport source (output valid, distance, inside_res, input ready);
  modport sink (input valid, distance, inside_res, output ready);
endinterface

>>> design/point_segment_distance_top.sv
// Top level of the point-to-segment distance unit.
// Depends on psd_pkg, psd_in_if, psd_out_if, psd_metric and psd_root_cell.

// The unit takes one item per clock and passes it through the input register, 4 stages of
// end-extension setup, a 23-cell square root chain for the extension length, the extended
// segment metric, a 32-cell square root chain for the distance and the output register. All
// stages advance together: while a result sits in the output register and is not taken,
// the whole pipeline holds and the input is not ready. The inside flag is worked out from
// the bare segment in parallel and carried along.
module point_segment_distance_top import psd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  psd_in_if.sink    in_i,
  psd_out_if.source out_o
);

  logic en;
  logic valid_q [0:ST_OUT];
  ctx_t ctx_q [0:ST_G-1];

  assign en         = !valid_q[ST_OUT] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= ST_OUT; k++) valid_q[k] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_i.valid;
      for (int k = 1; k <= ST_OUT; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[0].func   <= in_i.func;
      ctx_q[0].line_w <= in_i.line_width;
      ctx_q[0].sx     <= in_i.seg_start_x;
      ctx_q[0].sy     <= in_i.seg_start_y;
      ctx_q[0].ex     <= in_i.seg_end_x;
      ctx_q[0].ey     <= in_i.seg_end_y;
      ctx_q[0].px     <= in_i.point_x;
      ctx_q[0].py     <= in_i.point_y;
      for (int k = 1; k < ST_G; k++) ctx_q[k] <= ctx_q[k-1];
    end
  end

  // Bare segment metric.
  pts_t             bare_pts;
  logic [NUM_W-1:0] bnum;
  logic [DEN_W-1:0] bden;

  assign bare_pts.ax = CW'(ctx_q[0].sx);
  assign bare_pts.ay = CW'(ctx_q[0].sy);
  assign bare_pts.bx = CW'(ctx_q[0].ex);
  assign bare_pts.by = CW'(ctx_q[0].ey);
  assign bare_pts.px = CW'(ctx_q[0].px);
  assign bare_pts.py = CW'(ctx_q[0].py);

  psd_metric u_bare_metric (
    .clk_i (clk_i),
    .en_i  (en),
    .pts_i (bare_pts),
    .num_o (bnum),
    .den_o (bden)
  );

  logic [NUM_W-1:0] bnum_q [ST_BARE+1:ST_FIN_IN];
  logic [DEN_W-1:0] bden_q [ST_BARE+1:ST_FIN_IN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      bnum_q[ST_BARE+1] <= bnum;
      bden_q[ST_BARE+1] <= bden;
      for (int k = ST_BARE + 2; k <= ST_FIN_IN; k++) begin
        bnum_q[k] <= bnum_q[k-1];
        bden_q[k] <= bden_q[k-1];
      end
    end
  end

  // Inside flag: 4*num <= w^2*den, with the wide product split into four partial products.
  logic [2*WIDTH_W-1:0]      w2_q;
  logic [WIDTH_W+DW-1:0]     ip_hh_q, ip_hl_q, ip_lh_q, ip_ll_q;
  logic [NUM_W+1:0]          ins_lhs;
  logic [NUM_W+1:0]          ins_rhs;
  logic                      ins_q [ST_INS:ST_OUT];

  assign ins_lhs = {bnum_q[ST_BARE+2], 2'b00};
  assign ins_rhs = ((NUM_W+2)'(ip_hh_q) << (WIDTH_W + DW))
                 + ((NUM_W+2)'(ip_hl_q) << WIDTH_W)
                 + ((NUM_W+2)'(ip_lh_q) << DW)
                 + (NUM_W+2)'(ip_ll_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      w2_q    <= (2*WIDTH_W)'(ctx_q[ST_BARE].line_w) * (2*WIDTH_W)'(ctx_q[ST_BARE].line_w);
      ip_hh_q <= (WIDTH_W+DW)'(w2_q[2*WIDTH_W-1:WIDTH_W])
               * (WIDTH_W+DW)'(bden_q[ST_BARE+1][DEN_W-1:DW]);
      ip_hl_q <= (WIDTH_W+DW)'(w2_q[2*WIDTH_W-1:WIDTH_W])
               * (WIDTH_W+DW)'(bden_q[ST_BARE+1][DW-1:0]);
      ip_lh_q <= (WIDTH_W+DW)'(w2_q[WIDTH_W-1:0])
               * (WIDTH_W+DW)'(bden_q[ST_BARE+1][DEN_W-1:DW]);
      ip_ll_q <= (WIDTH_W+DW)'(w2_q[WIDTH_W-1:0])
               * (WIDTH_W+DW)'(bden_q[ST_BARE+1][DW-1:0]);
      ins_q[ST_INS] <= (ins_lhs <= ins_rhs);
      for (int k = ST_INS + 1; k <= ST_OUT; k++) ins_q[k] <= ins_q[k-1];
    end
  end

  // Extension setup: (|d|*w)^2 over |d|^2 for each axis.
  logic signed [MAG_W-1:0] ed_q [2];
  logic [MAG_W-1:0]        ead [2];
  logic [EPROD_W-1:0]      ep_q [2];
  logic [2*MAG_W-1:0]      esq_q [2];
  logic [EL2_W-1:0]        el2_q, el2d_q;
  logic [2*EHALF_W-1:0]    epp_hh_q [2];
  logic [2*EHALF_W-1:0]    epp_hl_q [2];
  logic [2*EHALF_W-1:0]    epp_ll_q [2];
  logic [ENUM_W-1:0]       enum_q [2];
  logic                    bsel_q [ST_EXT_IN:ST_FIN_IN];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      ead[a] = ed_q[a][MAG_W-1] ? MAG_W'(-ed_q[a]) : MAG_W'(ed_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ed_q[0] <= MAG_W'(ctx_q[0].ex) - MAG_W'(ctx_q[0].sx);
      ed_q[1] <= MAG_W'(ctx_q[0].ey) - MAG_W'(ctx_q[0].sy);
      for (int a = 0; a < 2; a++) begin
        ep_q[a]     <= EPROD_W'(ead[a]) * EPROD_W'(ctx_q[1].line_w);
        esq_q[a]    <= (2*MAG_W)'(ead[a]) * (2*MAG_W)'(ead[a]);
        epp_hh_q[a] <= (2*EHALF_W)'(ep_q[a][EPROD_W-1:EHALF_W])
                     * (2*EHALF_W)'(ep_q[a][EPROD_W-1:EHALF_W]);
        epp_hl_q[a] <= (2*EHALF_W)'(ep_q[a][EPROD_W-1:EHALF_W])
                     * (2*EHALF_W)'(ep_q[a][EHALF_W-1:0]);
        epp_ll_q[a] <= (2*EHALF_W)'(ep_q[a][EHALF_W-1:0])
                     * (2*EHALF_W)'(ep_q[a][EHALF_W-1:0]);
        enum_q[a]   <= (ENUM_W'(epp_hh_q[a]) << (2 * EHALF_W))
                     + (ENUM_W'(epp_hl_q[a]) << (EHALF_W + 1))
                     + ENUM_W'(epp_ll_q[a]);
      end
      el2_q  <= EL2_W'(esq_q[0]) + EL2_W'(esq_q[1]);
      el2d_q <= el2_q;
      // A zero-length segment or mode 1 takes the bare metric.
      bsel_q[ST_EXT_IN] <= ctx_q[ST_EXT_IN-1].func || (el2_q == '0);
      for (int k = ST_EXT_IN + 1; k <= ST_FIN_IN; k++) bsel_q[k] <= bsel_q[k-1];
    end
  end

  // Extension length chains, one per axis.
  root_t xin [2];
  root_t xr [2][1:EXT_BITS];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      xin[a].num = RW'(enum_q[a]);
      xin[a].sq  = '0;
      xin[a].y   = '0;
      xin[a].d2  = RW'(el2d_q) << (2 * (EXT_BITS - 1));
      xin[a].r   = '0;
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    for (genvar k = 1; k <= EXT_BITS; k++) begin : g_cell
      if (k == 1) begin : g_first
        psd_root_cell u_cell (
          .clk_i  (clk_i),
          .en_i   (en),
          .root_i (xin[a]),
          .root_o (xr[a][k])
        );
      end else begin : g_next
        psd_root_cell u_cell (
          .clk_i  (clk_i),
          .en_i   (en),
          .root_i (xr[a][k-1]),
          .root_o (xr[a][k])
        );
      end
    end
  end

  // Round the extension to nearest and push both ends outward.
  logic [EXT_BITS:0]    gsum [2];
  logic signed [CW-1:0] gext [2];
  pts_t                 ext_q;
  logic [NUM_W-1:0]     xnum;
  logic [DEN_W-1:0]     xden;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      gsum[a] = {1'b0, xr[a][EXT_BITS].r[EXT_BITS-1:0]} + (EXT_BITS+1)'(1);
    end
    gext[0] = (ctx_q[ST_G-1].ex < ctx_q[ST_G-1].sx) ? -CW'(gsum[0][EXT_BITS:1])
                                                    : CW'(gsum[0][EXT_BITS:1]);
    gext[1] = (ctx_q[ST_G-1].ey < ctx_q[ST_G-1].sy) ? -CW'(gsum[1][EXT_BITS:1])
                                                    : CW'(gsum[1][EXT_BITS:1]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ext_q.ax <= CW'(ctx_q[ST_G-1].sx) - gext[0];
      ext_q.ay <= CW'(ctx_q[ST_G-1].sy) - gext[1];
      ext_q.bx <= CW'(ctx_q[ST_G-1].ex) + gext[0];
      ext_q.by <= CW'(ctx_q[ST_G-1].ey) + gext[1];
      ext_q.px <= CW'(ctx_q[ST_G-1].px);
      ext_q.py <= CW'(ctx_q[ST_G-1].py);
    end
  end

  psd_metric u_ext_metric (
    .clk_i (clk_i),
    .en_i  (en),
    .pts_i (ext_q),
    .num_o (xnum),
    .den_o (xden)
  );

  // Final distance chain.
  root_t            fin;
  root_t            fr [1:FIN_BITS];
  logic [DEN_W-1:0] fden;

  assign fden = bsel_q[ST_FIN_IN] ? bden_q[ST_FIN_IN] : xden;

  always_comb begin
    fin.num = bsel_q[ST_FIN_IN] ? RW'(bnum_q[ST_FIN_IN]) : RW'(xnum);
    fin.sq  = '0;
    fin.y   = '0;
    fin.d2  = RW'(fden) << (2 * (FIN_BITS - 1));
    fin.r   = '0;
  end

  for (genvar k = 1; k <= FIN_BITS; k++) begin : g_fin
    if (k == 1) begin : g_first
      psd_root_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .root_i (fin),
        .root_o (fr[k])
      );
    end else begin : g_next
      psd_root_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .root_i (fr[k-1]),
        .root_o (fr[k])
      );
    end
  end

  logic [DIST_W-1:0] dist_q;

  // Distances beyond the field saturate to all ones.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= (|fr[FIN_BITS].r[FIN_BITS-1:DIST_W]) ? '1 : fr[FIN_BITS].r[DIST_W-1:0];
    end
  end

  assign out_o.valid      = valid_q[ST_OUT];
  assign out_o.distance   = dist_q;
  assign out_o.inside_res = ins_q[ST_OUT];

endmodule

>>> design/psd_root_cell.sv
// One cell of the ratio square root chain: decides one result bit of floor(sqrt(num/den)).
// Depends on psd_pkg.
module psd_root_cell import psd_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  root_t root_i,
  output root_t root_o
);

  // sq holds r^2*den, y holds r*den*2^(b+1) and d2 holds den*4^b for the bit b of this cell,
  // so trying the bit costs one three-input add and a compare.
  logic [RW-1:0] cand;
  logic          take;

  assign cand = root_i.sq + root_i.y + root_i.d2;
  assign take = (cand <= root_i.num);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_o.num <= root_i.num;
      root_o.sq  <= take ? cand : root_i.sq;
      root_o.y   <= (root_i.y >> 1) + (take ? root_i.d2 : '0);
      root_o.d2  <= root_i.d2 >> 2;
      root_o.r   <= {root_i.r[FIN_BITS-2:0], take};
    end
  end

endmodule

>>> design/psd_metric.sv
// Squared distance from a point to a segment, given as num/den, in five register stages.
// Depends on psd_pkg.
module psd_metric import psd_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  pts_t             pts_i,
  output logic [NUM_W-1:0] num_o,
  output logic [DEN_W-1:0] den_o
);

  logic signed [DW-1:0] dx_q, dy_q, vx_q, vy_q, wx_q, wy_q;
  logic signed [PW-1:0] pdx_q, pdy_q, cxa_q, cxb_q;
  logic [PW-1:0]        sdx_q, sdy_q, svx_q, svy_q, swx_q, swy_q;
  logic [DEN_W-1:0]     l2_q, l2_m_q;
  logic signed [PW:0]   dot_q, cr_q;
  logic [PW-1:0]        ev_q, ew_q, sel_q;
  logic [PW-1:0]        crm;
  logic                 int_q;
  logic [PW-1:0]        hh_q, hl_q, ll_q;

  assign crm = cr_q[PW] ? PW'(-cr_q) : PW'(cr_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= DW'(pts_i.bx) - DW'(pts_i.ax);
      dy_q <= DW'(pts_i.by) - DW'(pts_i.ay);
      vx_q <= DW'(pts_i.px) - DW'(pts_i.ax);
      vy_q <= DW'(pts_i.py) - DW'(pts_i.ay);
      wx_q <= DW'(pts_i.px) - DW'(pts_i.bx);
      wy_q <= DW'(pts_i.py) - DW'(pts_i.by);

      pdx_q <= PW'(vx_q) * PW'(dx_q);
      pdy_q <= PW'(vy_q) * PW'(dy_q);
      cxa_q <= PW'(vx_q) * PW'(dy_q);
      cxb_q <= PW'(vy_q) * PW'(dx_q);
      sdx_q <= PW'(dx_q) * PW'(dx_q);
      sdy_q <= PW'(dy_q) * PW'(dy_q);
      svx_q <= PW'(vx_q) * PW'(vx_q);
      svy_q <= PW'(vy_q) * PW'(vy_q);
      swx_q <= PW'(wx_q) * PW'(wx_q);
      swy_q <= PW'(wy_q) * PW'(wy_q);

      l2_q  <= sdx_q + sdy_q;
      dot_q <= (PW+1)'(pdx_q) + (PW+1)'(pdy_q);
      cr_q  <= (PW+1)'(cxa_q) - (PW+1)'(cxb_q);
      ev_q  <= svx_q + svy_q;
      ew_q  <= swx_q + swy_q;

      // Projection before the start or past the end gives an endpoint distance.
      if (l2_q == '0 || dot_q <= 0) begin
        sel_q <= ev_q;
        int_q <= 1'b0;
      end else if ($signed({1'b0, l2_q}) <= dot_q) begin
        sel_q <= ew_q;
        int_q <= 1'b0;
      end else begin
        sel_q <= ev_q;
        int_q <= 1'b1;
      end
      l2_m_q <= l2_q;
      hh_q   <= PW'(crm[PW-1:DW]) * PW'(crm[PW-1:DW]);
      hl_q   <= PW'(crm[PW-1:DW]) * PW'(crm[DW-1:0]);
      ll_q   <= PW'(crm[DW-1:0]) * PW'(crm[DW-1:0]);

      if (int_q) begin
        num_o <= (NUM_W'(hh_q) << (2 * DW)) + (NUM_W'(hl_q) << (DW + 1)) + NUM_W'(ll_q);
        den_o <= l2_m_q;
      end else begin
        num_o <= NUM_W'(sel_q);
        den_o <= DEN_W'(1);
      end
    end
  end

endmodule
